// ----- hw/rtl/utility_histogram_threshold_macros.svh -----
// Assertion macros shared by the utility histogram threshold RTL.
// Depends on nothing; files that assert include it by name.
`ifndef UTILITY_HISTOGRAM_THRESHOLD_MACROS_SVH
`define UTILITY_HISTOGRAM_THRESHOLD_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define UHT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define UHT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UHT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define UHT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/uht_pkg.sv -----
// Package for the utility histogram threshold block: sizes, request codes,
// the bucket edge table and the total saturation helper. No dependencies.
package uht_pkg;

  localparam int NUM_BUCKETS = 100;
  localparam int COUNT_BITS  = 32;
  localparam int IDX_W       = $clog2(NUM_BUCKETS);
  localparam int TARGET_W    = COUNT_BITS + 17;
  localparam int MIN_FOR_RECOMPUTE = 10;

  localparam logic [16:0] ONE_Q16       = 17'h10000;
  localparam logic [15:0] FRACTION_INIT = 16'd3277;

  localparam logic [1:0] REQ_ADD_HIGH  = 2'd0;
  localparam logic [1:0] REQ_ADD_LOW   = 2'd1;
  localparam logic [1:0] REQ_RECOMPUTE = 2'd2;

  typedef logic [16:0] thr_table_t [NUM_BUCKETS];

  // Upper edge of each bucket in Q1.16, floor((i+1)*65536/NUM_BUCKETS).
  function automatic thr_table_t make_thr_table();
    thr_table_t t;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      t[i] = 17'(((i + 1) * 65536) / NUM_BUCKETS);
    end
    return t;
  endfunction

  localparam thr_table_t THR_TABLE = make_thr_table();

  // Clamp a count to the 32-bit reporting width.
  function automatic logic [31:0] to_total(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+31:0] w;
    w = (COUNT_BITS + 32)'(v);
    if (w > (COUNT_BITS + 32)'(32'hFFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end
    return w[31:0];
  endfunction

endpackage

// ----- hw/rtl/uht_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on uht_pkg.
interface uht_req_if;
  import uht_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [16:0] utility;
  logic [15:0] container_count;

  modport source (output valid, req_type, utility, container_count, input ready);
  modport sink (input valid, req_type, utility, container_count, output ready);
endinterface

interface uht_res_if;
  import uht_pkg::*;
  logic        valid;
  logic        ready;
  logic [16:0] high_threshold;
  logic [16:0] low_threshold;
  logic [31:0] high_total;
  logic [31:0] low_total;

  modport source (output valid, high_threshold, low_threshold, high_total, low_total,
                  input ready);
  modport sink (input valid, high_threshold, low_threshold, high_total, low_total,
                output ready);
endinterface

// ----- hw/rtl/uht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/uht_satadd.sv -----
// Shared saturating adder used for every count update and the bucket scan.
// Depends on uht_pkg.
module uht_satadd (
  input  logic [uht_pkg::COUNT_BITS-1:0] a,
  input  logic [uht_pkg::COUNT_BITS-1:0] b,
  output logic [uht_pkg::COUNT_BITS-1:0] sum
);
  import uht_pkg::*;

  logic [COUNT_BITS:0] full;

  assign full = (COUNT_BITS + 1)'(a) + (COUNT_BITS + 1)'(b);
  assign sum  = full[COUNT_BITS] ? '1 : full[COUNT_BITS-1:0];

endmodule

// ----- hw/rtl/utility_histogram_threshold.sv -----
// Utility histogram threshold block: tracks container utilities in Q1.16.
// Requests come on the req channel (valid/ready); each accepted item produces
// exactly one result item on the res channel showing the state after it.
// Add-high bumps one of 100 histogram buckets and keeps the minimum utility;
// add-low adds a batch count and keeps the maximum utility; recompute scans
// the buckets to place the high threshold at the upper edge of the bucket
// where the running count reaches count*(1-rewrite_fraction), if count >= 10.
// rewrite_fraction is written through cfg_we/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it. Add-high reads
// its bucket, then writes it back; add-low updates directly; recompute forms
// the target, then reads and adds one bucket after another; an unused code
// goes straight to the result. The single shared saturating adder and the one
// read port of the bucket RAM serve one item at a time; req.ready is high only
// while the sequencer is idle, so the next item is taken after a result loads.
// A finished result sits in the output register; a new item is accepted while
// it waits, but the next result holds back until res.ready frees the register.
// Reset (rst, synchronous) zeroes counts and bucket valid bits, sets the high
// threshold to 1.0 and the low threshold to 0.
// Depends on uht_pkg, uht_ifs, uht_ram, uht_satadd and the macros header.
`include "utility_histogram_threshold_macros.svh"

module utility_histogram_threshold (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  uht_req_if.sink     req,
  uht_res_if.source   res
);
  import uht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HI_RD, S_HI_WR, S_LO, S_RC_MUL, S_RC_RD, S_RC_ACC, S_OUT
  } state_t;

  state_t state;

  logic [16:0]           util_q;
  logic [15:0]           num_q;
  logic [15:0]           frac;
  logic [COUNT_BITS-1:0] high_count;
  logic [COUNT_BITS-1:0] low_count;
  logic [16:0]           high_thr;
  logic [16:0]           low_thr;
  logic [NUM_BUCKETS-1:0] bkt_valid;
  logic [IDX_W-1:0]      bkt_idx;
  logic [IDX_W-1:0]      scan_idx;
  logic                  rd_valid;
  logic [COUNT_BITS-1:0] sum;
  logic [TARGET_W-1:0]   target;

  logic                  res_valid;
  logic [16:0]           out_hthr;
  logic [16:0]           out_lthr;
  logic [31:0]           out_htot;
  logic [31:0]           out_ltot;

  logic [16+IDX_W-1:0]   prod;
  logic [IDX_W-1:0]      hi_idx;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] bkt_rd;
  logic                  ram_we;
  logic [COUNT_BITS-1:0] add_a;
  logic [COUNT_BITS-1:0] add_b;
  logic [COUNT_BITS-1:0] add_sum;
  logic [16:0]           util_clamp;
  logic                  scan_hit;

  assign req.ready = (state == S_IDLE);

  assign res.valid          = res_valid;
  assign res.high_threshold = out_hthr;
  assign res.low_threshold  = out_lthr;
  assign res.high_total     = out_htot;
  assign res.low_total      = out_ltot;

  // Bucket index is floor(utility * NUM_BUCKETS / 65536), last bucket from 1.0 up.
  assign prod   = (16 + IDX_W)'(util_q[15:0]) * (16 + IDX_W)'(NUM_BUCKETS);
  assign hi_idx = util_q[16] ? IDX_W'(NUM_BUCKETS - 1) : prod[16+IDX_W-1:16];

  assign bkt_rd     = rd_valid ? ram_rdata : '0;
  assign util_clamp = (util_q > ONE_Q16) ? ONE_Q16 : util_q;
  assign ram_we     = (state == S_HI_WR);
  assign scan_hit   = (TARGET_W'({add_sum, 16'h0000}) >= target);

  always_comb begin
    case (state)
      S_HI_RD: ram_raddr = hi_idx;
      S_RC_RD: ram_raddr = scan_idx;
      default: ram_raddr = bkt_idx;
    endcase
  end

  always_comb begin
    case (state)
      S_HI_RD: begin
        add_a = high_count;
        add_b = COUNT_BITS'(1);
      end
      S_HI_WR: begin
        add_a = bkt_rd;
        add_b = COUNT_BITS'(1);
      end
      S_LO: begin
        add_a = low_count;
        add_b = COUNT_BITS'(num_q);
      end
      S_RC_ACC: begin
        add_a = sum;
        add_b = bkt_rd;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  uht_satadd u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  uht_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BUCKETS)
  ) u_buckets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bkt_idx),
    .wdata (add_sum),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      frac       <= FRACTION_INIT;
      high_count <= '0;
      low_count  <= '0;
      high_thr   <= ONE_Q16;
      low_thr    <= '0;
      bkt_valid  <= '0;
      rd_valid   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        frac <= cfg_wdata;
      end
      // A bucket never written reads as zero.
      rd_valid <= bkt_valid[ram_raddr];
      // In S_OUT the load below decides the output register alone.
      if (res_valid && res.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            util_q     <= req.utility;
            num_q      <= req.container_count;
            case (req.req_type)
              REQ_ADD_HIGH:  state <= S_HI_RD;
              REQ_ADD_LOW:   state <= S_LO;
              REQ_RECOMPUTE: state <= S_RC_MUL;
              default:       state <= S_OUT;
            endcase
          end
        end
        S_HI_RD: begin
          high_count <= add_sum;
          bkt_idx    <= hi_idx;
          if (util_q < high_thr) begin
            high_thr <= util_q;
          end
          state <= S_HI_WR;
        end
        S_HI_WR: begin
          bkt_valid[bkt_idx] <= 1'b1;
          state              <= S_OUT;
        end
        S_LO: begin
          low_count <= add_sum;
          if (util_clamp > low_thr) begin
            low_thr <= util_clamp;
          end
          state <= S_OUT;
        end
        S_RC_MUL: begin
          target   <= TARGET_W'(high_count) * TARGET_W'(ONE_Q16 - 17'(frac));
          sum      <= '0;
          scan_idx <= '0;
          if (high_count < COUNT_BITS'(MIN_FOR_RECOMPUTE)) begin
            state <= S_OUT;
          end else begin
            state <= S_RC_RD;
          end
        end
        S_RC_RD: begin
          state <= S_RC_ACC;
        end
        S_RC_ACC: begin
          sum <= add_sum;
          // The last bucket's edge is 1.0, which also covers a target never reached.
          if (scan_hit || scan_idx == IDX_W'(NUM_BUCKETS - 1)) begin
            high_thr <= THR_TABLE[scan_idx];
            state    <= S_OUT;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
            state    <= S_RC_RD;
          end
        end
        S_OUT: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            out_hthr  <= high_thr;
            out_lthr  <= low_thr;
            out_htot  <= to_total(high_count);
            out_ltot  <= to_total(low_count);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `UHT_ASSERT_NXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready, "ready stayed high after an item was accepted")
  `UHT_ASSERT_IMP(a_high_thr_range, clk, rst, 1'b1, high_thr <= ONE_Q16, "high threshold above 1.0")
  `UHT_ASSERT_IMP(a_low_thr_range, clk, rst, 1'b1, low_thr <= ONE_Q16, "low threshold above 1.0")
  `UHT_ASSERT_IMP(a_scan_range, clk, rst, state == S_RC_ACC, scan_idx <= IDX_W'(NUM_BUCKETS - 1), "scan index past the last bucket")
  `UHT_ASSERT_NXT(a_result_loaded, clk, rst, state == S_OUT && !res_valid, res_valid, "free output register was not loaded")

endmodule

// ----- test/utility_histogram_threshold_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for utility_histogram_threshold: drives request items
// with random gaps and stalls, predicts every result item and checks each field.
// Depends on uht_pkg, the uht_ifs channel interfaces and the block's RTL.
module utility_histogram_threshold_test;
  import uht_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 250;
  localparam int TIMEOUT_NS    = 20_000_000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [16:0] utility;
    logic [15:0] container_count;
  } util_req_t;

  typedef struct packed {
    logic [16:0] high_threshold;
    logic [16:0] low_threshold;
    logic [31:0] high_total;
    logic [31:0] low_total;
  } util_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  uht_req_if req_ch ();
  uht_res_if res_ch ();

  utility_histogram_threshold u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Predicted state of the block.
  logic [COUNT_BITS-1:0] bucket_cnt [NUM_BUCKETS];
  logic [COUNT_BITS-1:0] high_cnt;
  logic [COUNT_BITS-1:0] low_cnt;
  logic [16:0]           high_thr;
  logic [16:0]           low_thr;
  logic [15:0]           fraction;

  util_result_t pending_results [$];
  int           errors = 0;
  bit           no_idle = 1'b0;
  int           sink_hold = 0;
  int           util_center = 32768;

  function automatic void clear_model();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      bucket_cnt[i] = '0;
    end
    high_cnt = '0;
    low_cnt  = '0;
    high_thr = ONE_Q16;
    low_thr  = '0;
    fraction = FRACTION_INIT;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [31:0] clamp_total(input logic [COUNT_BITS-1:0] v);
    return (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  // Applies one request to the predicted state and returns the result it shows.
  function automatic util_result_t predict_thresholds(input util_req_t it);
    int                    idx;
    logic [COUNT_BITS-1:0] run_sum;
    logic [63:0]           target;
    bit                    found;
    logic [16:0]           clamped;
    util_result_t          r;
    case (it.req_type)
      REQ_ADD_HIGH: begin
        high_cnt = sat_add(high_cnt, COUNT_BITS'(1));
        if (it.utility < high_thr) high_thr = it.utility;
        if (it.utility >= ONE_Q16) idx = NUM_BUCKETS - 1;
        else idx = (int'(it.utility) * NUM_BUCKETS) >> 16;
        if (idx >= NUM_BUCKETS) idx = NUM_BUCKETS - 1;
        bucket_cnt[idx] = sat_add(bucket_cnt[idx], COUNT_BITS'(1));
      end
      REQ_ADD_LOW: begin
        clamped = (it.utility > ONE_Q16) ? ONE_Q16 : it.utility;
        low_cnt = sat_add(low_cnt, COUNT_BITS'(it.container_count));
        if (clamped > low_thr) low_thr = clamped;
      end
      REQ_RECOMPUTE: begin
        if (high_cnt >= MIN_FOR_RECOMPUTE) begin
          target  = 64'(high_cnt) * (64'(ONE_Q16) - 64'(fraction));
          run_sum = '0;
          idx     = NUM_BUCKETS - 1;
          found   = 1'b0;
          for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (!found) begin
              run_sum = sat_add(run_sum, bucket_cnt[i]);
              if ((64'(run_sum) << 16) >= target) begin
                idx   = i;
                found = 1'b1;
              end
            end
          end
          high_thr = 17'(((idx + 1) * 65536) / NUM_BUCKETS);
        end
      end
      default: begin
      end
    endcase
    r.high_threshold = high_thr;
    r.low_threshold  = low_thr;
    r.high_total     = clamp_total(high_cnt);
    r.low_total      = clamp_total(low_cnt);
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic util_req_t make_request(input logic [1:0] kind, input logic [16:0] util,
                                             input logic [15:0] num);
    util_req_t it;
    it.req_type        = kind;
    it.utility         = util;
    it.container_count = num;
    return it;
  endfunction

  function automatic util_req_t rand_request();
    util_req_t it;
    int        r;
    int        u;
    r = $urandom_range(0, 99);
    if (r < 45) it.req_type = REQ_ADD_HIGH;
    else if (r < 75) it.req_type = REQ_ADD_LOW;
    else if (r < 93) it.req_type = REQ_RECOMPUTE;
    else it.req_type = REQ_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.utility = ONE_Q16;
    end else if (r < 8) begin
      it.utility = 17'($urandom_range(65537, 131071));
    end else if (r < 11) begin
      it.utility = '0;
    end else if (r < 45) begin
      // Cluster around the phase center so the scan ends at varied buckets.
      u = util_center + $urandom_range(0, 4000) - 2000;
      if (u < 0) u = 0;
      if (u > 65535) u = 65535;
      it.utility = 17'(u);
    end else begin
      it.utility = 17'($urandom_range(0, 65535));
    end
    r = $urandom_range(0, 99);
    if (r < 5) it.container_count = '0;
    else if (r < 10) it.container_count = 16'hFFFF;
    else it.container_count = 16'($urandom);
    return it;
  endfunction

  task automatic send_request(input util_req_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= it.req_type;
    req_ch.utility         <= it.utility;
    req_ch.container_count <= it.container_count;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_thresholds(it));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [15:0] v);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    fraction = v;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      res_ch.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) sink_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    util_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected, actual %0d %0d %0d %0d", $time,
                 res_ch.high_threshold, res_ch.low_threshold, res_ch.high_total,
                 res_ch.low_total);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("high_threshold", 32'(want.high_threshold), 32'(res_ch.high_threshold));
        check_field("low_threshold", 32'(want.low_threshold), 32'(res_ch.low_threshold));
        check_field("high_total", want.high_total, res_ch.high_total);
        check_field("low_total", want.low_total, res_ch.low_total);
      end
    end
  end

  // Edge values, every request kind, clamping above 1.0 and the short-count recompute.
  task automatic test_directed();
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
    send_request(make_request(REQ_UNUSED, 17'h1FFFF, 16'hFFFF));
    send_request(make_request(REQ_ADD_LOW, 17'd0, 16'd0));
    send_request(make_request(REQ_ADD_LOW, 17'h1FFFF, 16'hFFFF));
    send_request(make_request(REQ_ADD_LOW, ONE_Q16, 16'hFFFF));
    send_request(make_request(REQ_ADD_LOW, 17'd1234, 16'd1));
    send_request(make_request(REQ_ADD_HIGH, ONE_Q16, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'h1FFFF, 16'hFFFF));
    send_request(make_request(REQ_ADD_HIGH, 17'd65535, 16'd0));
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd655, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd656, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd32768, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd1, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd98000, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd60000, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd0, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd64880, 16'd0));
    send_request(make_request(REQ_RECOMPUTE, 17'h1FFFF, 16'hFFFF));
    send_request(make_request(REQ_ADD_LOW, 17'h0FFFF, 16'h5555));
    send_request(make_request(REQ_UNUSED, 17'd0, 16'd0));
  endtask

  // A zero fraction needs every container; the largest one stops at the first bucket.
  task automatic test_fraction_extremes();
    write_fraction(16'd0);
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd40000, 16'd0));
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
    write_fraction(16'hFFFF);
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
    send_request(make_request(REQ_ADD_HIGH, 17'd0, 16'd0));
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
    write_fraction(FRACTION_INIT);
    send_request(make_request(REQ_RECOMPUTE, 17'd0, 16'd0));
  endtask

  task automatic test_random();
    int per_phase;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_fraction(16'd0);
        1: write_fraction(16'hFFFF);
        2: write_fraction(16'd32768);
        3: write_fraction(FRACTION_INIT);
        default: write_fraction(16'($urandom));
      endcase
      no_idle     = (p == 2);
      util_center = $urandom_range(2000, 63000);
      for (int n = 0; n < per_phase; n++) begin
        // Hold the sender back once per phase until the block has caught up.
        if (n == per_phase / 2) drain_results();
        send_request(rand_request());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_model();
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_ADD_HIGH;
    req_ch.utility         = '0;
    req_ch.container_count = '0;
    res_ch.ready           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fraction_extremes();
    test_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("utility_histogram_threshold_test: PASS");
    end else begin
      $display("utility_histogram_threshold_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("utility_histogram_threshold_test: FAIL");
    $finish;
  end

endmodule

// ----- utility_histogram_threshold.f -----
+incdir+hw/rtl
hw/rtl/uht_pkg.sv
hw/rtl/uht_ifs.sv
hw/rtl/uht_ram.sv
hw/rtl/uht_satadd.sv
hw/rtl/utility_histogram_threshold.sv
test/utility_histogram_threshold_test.sv
